FILE: hdl/spjq_pkg.sv
// Package for the sorted priority job queue.
// Holds status and mode codes, field widths and the cell control struct; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spjq_pkg;

  localparam int unsigned JobW  = 16;
  localparam int unsigned PrioW = 8;
  localparam int unsigned OccW  = 4;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } spjq_status_e;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } spjq_mode_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert a new job into the sorted row
    logic del;  // remove the head, each cell takes its right neighbor (the last cell holds)
  } spjq_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/spjq_cell.sv
// One slot of the sorted row: a job number and a priority.
// Depends on spjq_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module spjq_cell
  import spjq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire spjq_ctrl_t       ctrl_i,
  input  wire logic             occupied_i,
  input  wire logic [JobW-1:0]  new_job_i,
  input  wire logic [PrioW-1:0] new_prio_i,
  input  wire logic             left_keep_i,
  input  wire logic [JobW-1:0]  left_job_i,
  input  wire logic [PrioW-1:0] left_prio_i,
  input  wire logic [JobW-1:0]  right_job_i,
  input  wire logic [PrioW-1:0] right_prio_i,
  output logic                  keep_o,
  output logic [JobW-1:0]       job_o,
  output logic [PrioW-1:0]      prio_o
);

  logic [JobW-1:0]  job_q, job_d;
  logic [PrioW-1:0] prio_q, prio_d;

  // Held job stays ahead of the new one: equal priority keeps arrival order
  assign keep_o = occupied_i && (prio_q <= new_prio_i);

  // Insert: keep, take the new job at the boundary, or shift up from the left.
  // Remove: shift down from the right.
  always_comb begin
    job_d  = job_q;
    prio_d = prio_q;
    if (ctrl_i.del) begin
      job_d  = right_job_i;
      prio_d = right_prio_i;
    end else if (ctrl_i.ins && !keep_o) begin
      if (left_keep_i) begin
        job_d  = new_job_i;
        prio_d = new_prio_i;
      end else begin
        job_d  = left_job_i;
        prio_d = left_prio_i;
      end
    end
  end

  // Payload only, no reset needed
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    prio_q <= prio_d;
  end

  assign job_o  = job_q;
  assign prio_o = prio_q;

endmodule

`default_nettype wire

FILE: hdl/sorted_priority_job_queue_top.sv
// Top level of the sorted priority job queue: a row of DEPTH spjq_cell slots,
// a fill count and a registered result. Depends on spjq_pkg and spjq_cell.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------
//  in      | input     | in_valid_i / in_ready_o  | mode, job_number, priority_req
//  out     | output    | out_valid_o / out_ready_i| status, removed_job, removed_priority,
//          |           |                          | occupancy
//
// For each item every cell compares and shifts in parallel, and
// the result lands in the output register on the accept edge.
// A new item is taken whenever the output register is empty or being drained,
// so items flow one per cycle while the output side keeps up.
// A stalled output holds its result and blocks input until it is taken.
// Reset clears the fill count and the output valid; slot contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_job_queue_top
  import spjq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             mode_i,
  input  wire logic [JobW-1:0]  job_number_i,
  input  wire logic [PrioW-1:0] priority_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            status_o,
  output logic [JobW-1:0]       removed_job_o,
  output logic [PrioW-1:0]      removed_priority_o,
  output logic [OccW-1:0]       occupancy_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic            accept;
  logic            is_full, is_empty;
  spjq_ctrl_t      ctrl;
  logic [CntW-1:0] count_q, count_d;

  logic                  out_valid_q;
  spjq_status_e          status_q, status_d;
  logic [JobW-1:0]       rjob_q, rjob_d;
  logic [PrioW-1:0]      rprio_q, rprio_d;
  logic [CntW+OccW-1:0]  count_ext;

  logic [DEPTH-1:0]      keep;
  logic [JobW-1:0]       job   [DEPTH];
  logic [PrioW-1:0]      prio  [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q >= DepthC);
  assign is_empty   = (count_q == '0);

  // Command to the row
  assign ctrl.ins = accept && (mode_i == MODE_INSERT) && !is_full;
  assign ctrl.del = accept && (mode_i == MODE_REMOVE) && !is_empty;

  // Row of cells; cell 0 sees a keeping left neighbor, the last cell holds on remove
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    logic             left_keep;
    logic [JobW-1:0]  left_job, right_job;
    logic [PrioW-1:0] left_prio, right_prio;

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_job  = job[i];
      assign left_prio = prio[i];
    end else begin : g_mid
      assign left_keep = keep[i-1];
      assign left_job  = job[i-1];
      assign left_prio = prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_job  = job[i];
      assign right_prio = prio[i];
    end else begin : g_inner
      assign right_job  = job[i+1];
      assign right_prio = prio[i+1];
    end

    spjq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (Idx < count_q),
      .new_job_i    (job_number_i),
      .new_prio_i   (priority_req_i),
      .left_keep_i  (left_keep),
      .left_job_i   (left_job),
      .left_prio_i  (left_prio),
      .right_job_i  (right_job),
      .right_prio_i (right_prio),
      .keep_o       (keep[i]),
      .job_o        (job[i]),
      .prio_o       (prio[i])
    );
  end

  // Fill count and result
  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    rjob_d   = rjob_q;
    rprio_d  = rprio_q;
    if (accept) begin
      rjob_d  = '0;
      rprio_d = '0;
      if (mode_i == MODE_INSERT) begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          count_d  = count_q + 1'b1;
        end
      end else begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d = ST_REMOVED;
          rjob_d   = job[0];
          rprio_d  = prio[0];
          count_d  = count_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rjob_q   <= rjob_d;
    rprio_q  <= rprio_d;
  end

  assign count_ext          = {{OccW{1'b0}}, count_q};
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign removed_job_o      = rjob_q;
  assign removed_priority_o = rprio_q;
  assign occupancy_o        = count_ext[OccW-1:0];

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("fill count above depth");

  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item produced no result");

  a_refused_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_INSERT) && is_full) |=> (count_q == $past(count_q)))
    else $error("refused insert changed the fill count");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the fill count");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_EMPTY)) |-> (rjob_q == '0 && rprio_q == '0))
    else $error("empty result carries a job");

endmodule

`default_nettype wire

FILE: tb/sv/spjq_order_check_pkg.sv
// Ordering tracker for the sorted priority job queue testbench.
// Mirrors the sorted job store and queues the result due for every accepted item.
// Depends on spjq_pkg for widths, status and mode codes.
`timescale 1ns / 1ps

package spjq_order_check_pkg;

  import spjq_pkg::*;

  // One result as the block should report it
  typedef struct packed {
    spjq_status_e     status;
    logic [JobW-1:0]  job;
    logic [PrioW-1:0] prio;
    logic [OccW-1:0]  occ;
  } job_reply_t;

  class job_order_tracker #(int unsigned DEPTH = 8);

    logic [JobW-1:0]  held_job  [DEPTH];
    logic [PrioW-1:0] held_prio [DEPTH];
    int unsigned      held_count;
    job_reply_t       due_replies[$];
    int unsigned      mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted item to the mirrored store and queue its result
    function void note_request(spjq_mode_e mode, logic [JobW-1:0] job,
                               logic [PrioW-1:0] prio);
      job_reply_t  r;
      int unsigned slot;
      r.status = ST_INSERTED;
      r.job    = '0;
      r.prio   = '0;
      if (mode == MODE_INSERT) begin
        if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new job lands behind every job of equal or better priority
          slot = 0;
          while (slot < held_count && held_prio[slot] <= prio) slot++;
          for (int k = held_count; k > slot; k--) begin
            held_job[k]  = held_job[k-1];
            held_prio[k] = held_prio[k-1];
          end
          held_job[slot]  = job;
          held_prio[slot] = prio;
          held_count++;
        end
      end else begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_REMOVED;
          r.job    = held_job[0];
          r.prio   = held_prio[0];
          for (int k = 1; k < held_count; k++) begin
            held_job[k-1]  = held_job[k];
            held_prio[k-1] = held_prio[k];
          end
          held_count--;
        end
      end
      r.occ = OccW'(held_count);
      due_replies.push_back(r);
    endfunction

    // Compare one accepted result with the oldest one due
    function void check_reply(logic [1:0] status, logic [JobW-1:0] job,
                              logic [PrioW-1:0] prio, logic [OccW-1:0] occ);
      job_reply_t want;
      if (due_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with no item outstanding: status %0d job %h prio %h occ %0d",
                   $realtime, status, job, prio, occ);
      end else begin
        want = due_replies.pop_front();
        if (status !== want.status || job !== want.job || prio !== want.prio ||
            occ !== want.occ) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] mismatch: status exp %0d got %0d, job exp %h got %h, ",
                      "prio exp %h got %h, occ exp %0d got %0d"},
                     $realtime, want.status, status, want.job, job, want.prio, prio,
                     want.occ, occ);
        end
      end
    endfunction

  endclass

endpackage

FILE: tb/sv/tb_top.sv
// Testbench top for sorted_priority_job_queue_top: directed and random insert/remove items.
// Depends on spjq_pkg, spjq_order_check_pkg and the queue RTL.
`timescale 1ns / 1ps

module tb_top;

  import spjq_pkg::*;
  import spjq_order_check_pkg::*;

  localparam int unsigned DEPTH        = 8;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned LIMIT_CYCLES = 400000;

  logic             clk_i;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic             mode_i         = MODE_INSERT;
  logic [JobW-1:0]  job_number_i   = '0;
  logic [PrioW-1:0] priority_req_i = '0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  logic [1:0]       status_o;
  logic [JobW-1:0]  removed_job_o;
  logic [PrioW-1:0] removed_priority_o;
  logic [OccW-1:0]  occupancy_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  spjq_order_check_pkg::job_order_tracker #(DEPTH) order_track = new();

  sorted_priority_job_queue_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .job_number_i      (job_number_i),
    .priority_req_i    (priority_req_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .removed_job_o     (removed_job_o),
    .removed_priority_o(removed_priority_o),
    .occupancy_o       (occupancy_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** sorted_priority_job_queue_top: FAILED **");
      $finish;
    end
  end

  // Result side backpressure
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      order_track.check_reply(status_o, removed_job_o, removed_priority_o, occupancy_o);
  end

  // Present one item, hold it until accepted; called and returns at a falling edge
  task automatic push_item(input spjq_mode_e mode, input logic [JobW-1:0] job,
                           input logic [PrioW-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    mode_i         = mode;
    job_number_i   = job;
    priority_req_i = prio;
    do @(posedge clk_i); while (!in_ready_o);
    order_track.note_request(mode, job, prio);
    @(negedge clk_i);
  endtask

  // Random bursts that swing the store between empty and full
  task automatic run_random(input int unsigned count);
    int unsigned      sent;
    int unsigned      burst;
    int unsigned      insert_pct;
    int unsigned      pick;
    logic [PrioW-1:0] prio;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(2);
      insert_pct = (pick == 0) ? 85 : (pick == 1) ? 50 : 15;
      burst = $urandom_range(8, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        pick = $urandom_range(99);
        // few distinct priorities give many ties
        if (pick < 50)      prio = PrioW'($urandom_range(0, 3));
        else if (pick < 60) prio = ($urandom_range(1) != 0) ? '1 : '0;
        else                prio = PrioW'($urandom);
        if ($urandom_range(99) < insert_pct)
          push_item(MODE_INSERT, JobW'($urandom), prio);
        else
          push_item(MODE_REMOVE, JobW'($urandom), prio);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty remove, extremes, ties, full refusal, drain
    push_item(MODE_REMOVE, 16'hFFFF, 8'hFF);
    push_item(MODE_INSERT, 16'hFFFF, 8'hFF);
    push_item(MODE_INSERT, 16'h0000, 8'h00);
    push_item(MODE_INSERT, 16'h5A5A, 8'h80);
    push_item(MODE_INSERT, 16'hA5A5, 8'h80);
    push_item(MODE_INSERT, 16'h0001, 8'h7F);
    push_item(MODE_INSERT, 16'h8000, 8'h01);
    push_item(MODE_INSERT, 16'h7FFF, 8'hFE);
    push_item(MODE_INSERT, 16'h0F0F, 8'h80);
    push_item(MODE_INSERT, 16'h1234, 8'h00);
    for (int i = 0; i < DEPTH; i++)
      push_item(MODE_REMOVE, 16'h0000, 8'h00);
    push_item(MODE_REMOVE, 16'h0000, 8'h00);

    // Random phases: no idling, sender idle, receiver stall, both
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct = 55;
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct  = 0;
    recv_stall_pct = 55;
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    run_random(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4));
    in_valid_i = 1'b0;

    // Drain, then a short quiet tail
    while (order_track.due_replies.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (order_track.mismatches == 0 && order_track.due_replies.size() == 0) begin
      $display("** sorted_priority_job_queue_top: PASSED **");
    end else begin
      $display("** sorted_priority_job_queue_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/spjq_pkg.sv
hdl/spjq_cell.sv
hdl/sorted_priority_job_queue_top.sv
tb/sv/spjq_order_check_pkg.sv
tb/sv/tb_top.sv
